FILE: rtl/core/abl_pkg.sv
// ============================================================================
// abl_pkg: shared types and constants of the ARP binding table
// Table size, derived widths, result codes and the command and status groups
// exchanged between the controller and the datapath.
// ============================================================================
package abl_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    // Field widths of the message and the result.
    localparam int OP_W     = 16;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 6;
    localparam int ENTRY_BITS = IP_W + MAC_W;

    // ARP operation code of a reply.
    localparam logic [OP_W-1:0] REPLY_OPCODE = 16'd2;

    // Result codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED = 3'd0,
        ST_MATCH   = 3'd1,
        ST_SPOOF   = 3'd2,
        ST_LEARNED = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic step;
        logic decide;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_reply;
        logic hit;
        logic exhausted;
    } t_stat;

    // Reports a table slot on the fixed-width entry index field, modulo 64.
    function automatic logic [ENTRY_W-1:0] to_entry(input logic [IDX_W-1:0] idx);
        logic [IDX_W+ENTRY_W-1:0] wide;
        wide = {{ENTRY_W{1'b0}}, idx};
        return wide[ENTRY_W-1:0];
    endfunction

endpackage

FILE: rtl/core/abl_if.sv
// ============================================================================
// abl_if: valid/ready channels of the ARP binding table
// One interface for the message channel and one for the result channel.
// ============================================================================

// Parsed ARP message channel.
interface abl_msg_if;
    logic                          valid;
    logic                          ready;
    logic [abl_pkg::OP_W-1:0]      arp_opcode;
    logic [abl_pkg::IP_W-1:0]      sender_ip;
    logic [abl_pkg::MAC_W-1:0]     sender_mac;

    modport source (output valid, arp_opcode, sender_ip, sender_mac, input ready);
    modport sink   (input valid, arp_opcode, sender_ip, sender_mac, output ready);
endinterface

// Lookup result channel.
interface abl_res_if;
    logic                          valid;
    logic                          ready;
    logic [abl_pkg::STATUS_W-1:0]  status;
    logic [abl_pkg::MAC_W-1:0]     stored_mac;
    logic [abl_pkg::ENTRY_W-1:0]   entry_index;

    modport source (output valid, status, stored_mac, entry_index, input ready);
    modport sink   (input valid, status, stored_mac, entry_index, output ready);
endinterface

FILE: rtl/core/abl_ram.sv
// ============================================================================
// abl_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
module abl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic                              i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/abl_dpath.sv
// ============================================================================
// abl_dpath: datapath of the ARP binding table
// Holds the message, the fill count, the binding RAM, the search counter and
// the result registers, and carries out the controller's commands.
// ============================================================================
module abl_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  abl_pkg::t_cmd                 i_cmd,
    output abl_pkg::t_stat                o_stat,
    input  logic [abl_pkg::OP_W-1:0]      i_arp_opcode,
    input  logic [abl_pkg::IP_W-1:0]      i_sender_ip,
    input  logic [abl_pkg::MAC_W-1:0]     i_sender_mac,
    output logic [abl_pkg::STATUS_W-1:0]  o_status,
    output logic [abl_pkg::MAC_W-1:0]     o_stored_mac,
    output logic [abl_pkg::ENTRY_W-1:0]   o_entry_index
);

    // Latched message.
    logic [abl_pkg::OP_W-1:0]      r_op;
    logic [abl_pkg::IP_W-1:0]      r_ip;
    logic [abl_pkg::MAC_W-1:0]     r_mac;

    // Table and search state.
    logic [abl_pkg::FILL_W-1:0]    r_fill;
    logic [abl_pkg::FILL_W-1:0]    r_addr;
    logic [abl_pkg::IDX_W-1:0]     r_cmp_idx;
    logic                          r_rd_valid;

    // Pending result and output registers.
    abl_pkg::t_status              r_res_status;
    logic [abl_pkg::MAC_W-1:0]     r_res_mac;
    logic [abl_pkg::IDX_W-1:0]     r_res_idx;
    abl_pkg::t_status              r_out_status;
    logic [abl_pkg::MAC_W-1:0]     r_out_mac;
    logic [abl_pkg::ENTRY_W-1:0]   r_out_idx;

    // RAM signals.
    logic                          issue;
    logic                          learn;
    logic [abl_pkg::ENTRY_BITS-1:0] rdata;
    logic [abl_pkg::IP_W-1:0]      rd_ip;
    logic [abl_pkg::MAC_W-1:0]     rd_mac;
    logic                          is_reply;
    logic                          hit;
    logic                          exhausted;
    logic                          room;

    // A read is issued while slots below the fill count remain.
    assign issue = i_cmd.step && (r_addr < r_fill);

    assign rd_ip  = rdata[abl_pkg::ENTRY_BITS-1:abl_pkg::MAC_W];
    assign rd_mac = rdata[abl_pkg::MAC_W-1:0];

    assign is_reply  = (r_op == abl_pkg::REPLY_OPCODE);
    assign hit       = r_rd_valid && (rd_ip == r_ip);
    assign exhausted = !r_rd_valid && (r_addr == r_fill);
    assign room      = (r_fill < abl_pkg::FILL_W'(abl_pkg::TABLE_ENTRIES));

    // An unknown IP is appended when the decision falls on a free slot.
    assign learn = i_cmd.decide && is_reply && !hit && exhausted && room;

    assign o_stat = '{is_reply: is_reply, hit: hit, exhausted: exhausted};

    // Binding RAM: sender IP above sender MAC in each word.
    abl_ram #(
        .WIDTH (abl_pkg::ENTRY_BITS),
        .DEPTH (abl_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (learn),
        .i_waddr (r_fill[abl_pkg::IDX_W-1:0]),
        .i_wdata ({r_ip, r_mac}),
        .i_re    (issue),
        .i_raddr (r_addr[abl_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // Fill count and search control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_addr     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_addr     <= '0;
                r_rd_valid <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_valid <= issue;
                if (issue) begin
                    r_addr <= r_addr + abl_pkg::FILL_W'(1);
                end
            end
            if (learn) begin
                r_fill <= r_fill + abl_pkg::FILL_W'(1);
            end
        end
    end

    // Message latch and the slot of the word on the RAM output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_arp_opcode;
            r_ip  <= i_sender_ip;
            r_mac <= i_sender_mac;
        end
        if (issue) begin
            r_cmp_idx <= r_addr[abl_pkg::IDX_W-1:0];
        end
    end

    // Decision: ignored, match, spoof alert, learned or table full.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_mac <= '0;
            r_res_idx <= '0;
            if (!is_reply) begin
                r_res_status <= abl_pkg::ST_IGNORED;
            end else if (hit) begin
                r_res_idx <= r_cmp_idx;
                if (rd_mac != r_mac) begin
                    r_res_status <= abl_pkg::ST_SPOOF;
                    r_res_mac    <= rd_mac;
                end else begin
                    r_res_status <= abl_pkg::ST_MATCH;
                end
            end else if (room) begin
                r_res_status <= abl_pkg::ST_LEARNED;
                r_res_idx    <= r_fill[abl_pkg::IDX_W-1:0];
            end else begin
                r_res_status <= abl_pkg::ST_FULL;
            end
        end
    end

    // Output register, loaded when the result channel has room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_mac    <= r_res_mac;
            r_out_idx    <= abl_pkg::to_entry(r_res_idx);
        end
    end

    assign o_status      = r_out_status;
    assign o_stored_mac  = r_out_mac;
    assign o_entry_index = r_out_idx;

endmodule

FILE: rtl/core/abl_ctrl.sv
// ============================================================================
// abl_ctrl: controller of the ARP binding table
// Sequences accept, table search, decision and hand-off to the output
// register, and owns both handshakes.
// ============================================================================
module abl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  abl_pkg::t_stat  i_stat,
    output abl_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   done;
    logic   load;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign done   = !i_stat.is_reply || i_stat.hit || i_stat.exhausted;
    assign load   = (r_state == S_POST) && (!r_out_valid || i_out_ready);

    // Next state and output valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands to the datapath.
    assign o_cmd = '{
        start:    accept,
        step:     (r_state == S_SEARCH),
        decide:   (r_state == S_SEARCH) && done,
        load_out: load
    };

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/arp_binding_learn_check.sv
// ============================================================================
// arp_binding_learn_check: ARP reply binding learn and spoof check
// Learns IPv4-to-MAC bindings from ARP replies and flags replies whose MAC
// contradicts a learned binding.
// ============================================================================
// Usage:
//   i_arp carries one parsed ARP message per item (opcode, sender IP and
//   sender MAC). o_res returns exactly one result item per message: status,
//   the stored MAC on a spoof alert, and the table slot involved.
//   Messages are handled one at a time. A non-reply is decided without a
//   table search. A reply walks the learned slots through the single
//   read port of the binding RAM, one slot per cycle, and stops at the
//   first matching slot or after the last learned one; with an empty
//   table no slot is read. A full table holds 64 slots.
//   The result sits in an output register; the next message is accepted while
//   it waits. If the receiver stalls, a second finished result is held back
//   until the first is taken, and no further message is accepted meanwhile.
//   Reset clears the fill count and the handshake state at once; the table
//   contents need no clearing because only slots below the fill count are
//   read. The block is ready in the first cycle after reset.
module arp_binding_learn_check (
    input  logic   i_clk,
    input  logic   i_rst_n,
    abl_msg_if.sink   i_arp,
    abl_res_if.source o_res
);

    abl_pkg::t_cmd  cmd;
    abl_pkg::t_stat stat;

    // Controller: sequencing and handshakes.
    abl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_arp.valid),
        .o_in_ready  (i_arp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: table, search and result registers.
    abl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_arp_opcode  (i_arp.arp_opcode),
        .i_sender_ip   (i_arp.sender_ip),
        .i_sender_mac  (i_arp.sender_mac),
        .o_status      (o_res.status),
        .o_stored_mac  (o_res.stored_mac),
        .o_entry_index (o_res.entry_index)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: regression of the ARP binding learn-and-check table
// Parsed ARP messages are fed from a backlog queue, with random gaps and long
// receiver stalls. An independent copy of the binding table predicts each
// result as its message is accepted, and each result item is compared field
// by field with the oldest prediction.
// ============================================================================
module testbench;

    // Timing and stimulus shape.
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 930;
    localparam int POOL_SIZE    = 96;
    localparam int IDLE_PCT     = 17;
    localparam int QUIET_FIRST  = 400;
    localparam int QUIET_LAST   = 560;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;

    // Opcodes that must be ignored.
    localparam logic [abl_pkg::OP_W-1:0] OP_REQUEST       = 16'd1;
    localparam logic [abl_pkg::OP_W-1:0] OP_RARP_REQUEST  = 16'd3;
    localparam logic [abl_pkg::OP_W-1:0] OP_REPLY_SWAPPED = 16'h0200;
    localparam logic [abl_pkg::OP_W-1:0] OP_REPLY_HIGHBIT = 16'h8002;

    typedef struct packed {
        logic [abl_pkg::OP_W-1:0]  opcode;
        logic [abl_pkg::IP_W-1:0]  ip;
        logic [abl_pkg::MAC_W-1:0] mac;
    } t_arp_msg;

    typedef struct packed {
        abl_pkg::t_status            status;
        logic [abl_pkg::MAC_W-1:0]   stored_mac;
        logic [abl_pkg::ENTRY_W-1:0] entry_index;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    abl_msg_if arp_ch ();
    abl_res_if res_ch ();

    arp_binding_learn_check DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_arp   (arp_ch.sink),
        .o_res   (res_ch.source)
    );

    // Predicted binding table.
    logic [abl_pkg::IP_W-1:0]  bind_ip  [abl_pkg::TABLE_ENTRIES];
    logic [abl_pkg::MAC_W-1:0] bind_mac [abl_pkg::TABLE_ENTRIES];
    int               bind_fill = 0;

    t_arp_msg arp_backlog[$];
    t_verdict expected_verdicts[$];
    t_arp_msg msg_on_wire = '0;
    int       accepted_msgs = 0;
    int       taken_results = 0;
    int       error_count   = 0;
    int       idle_run      = 0;
    int       hold_left     = 0;
    int       hold_points[$] = '{150, 700};

    // Clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Looks a reply up in the predicted table, learning unknown IPs while room is left.
    function automatic t_verdict bind_lookup(t_arp_msg m);
        t_verdict v;
        int       slot;
        v = '{status: abl_pkg::ST_IGNORED, stored_mac: '0, entry_index: '0};
        if (m.opcode != abl_pkg::REPLY_OPCODE)
            return v;
        for (slot = 0; slot < bind_fill; slot++) begin
            if (bind_ip[slot] == m.ip) begin
                v.entry_index = slot[abl_pkg::ENTRY_W-1:0];
                if (bind_mac[slot] != m.mac) begin
                    v.status     = abl_pkg::ST_SPOOF;
                    v.stored_mac = bind_mac[slot];
                end else begin
                    v.status = abl_pkg::ST_MATCH;
                end
                return v;
            end
        end
        if (bind_fill < abl_pkg::TABLE_ENTRIES) begin
            bind_ip[bind_fill]  = m.ip;
            bind_mac[bind_fill] = m.mac;
            v.status            = abl_pkg::ST_LEARNED;
            v.entry_index       = bind_fill[abl_pkg::ENTRY_W-1:0];
            bind_fill++;
        end else begin
            v.status = abl_pkg::ST_FULL;
        end
        return v;
    endfunction

    function automatic logic [abl_pkg::MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic queue_msg(logic [abl_pkg::OP_W-1:0] op, logic [abl_pkg::IP_W-1:0] ip,
                             logic [abl_pkg::MAC_W-1:0] mac);
        arp_backlog.push_back('{opcode: op, ip: ip, mac: mac});
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: result %0d: %s: got %h, expected %h",
                 $realtime, taken_results, what, got, want);
        error_count++;
    endtask

    // Sender: offers the next message from the backlog, idling at random.
    always @(posedge i_clk) begin
        logic offering;
        logic idle_now;
        if (!i_rst_n) begin
            arp_ch.valid <= 1'b0;
        end else begin
            offering = arp_ch.valid;
            if (arp_ch.valid && arp_ch.ready) begin
                expected_verdicts.push_back(bind_lookup(msg_on_wire));
                accepted_msgs++;
                offering = 1'b0;
            end
            idle_now = !(accepted_msgs >= QUIET_FIRST && accepted_msgs < QUIET_LAST)
                       && ($urandom_range(99) < IDLE_PCT);
            if (!offering && arp_backlog.size() > 0 && !idle_now) begin
                msg_on_wire = arp_backlog.pop_front();
                offering    = 1'b1;
            end
            arp_ch.valid      <= offering;
            arp_ch.arp_opcode <= msg_on_wire.opcode;
            arp_ch.sender_ip  <= msg_on_wire.ip;
            arp_ch.sender_mac <= msg_on_wire.mac;
        end
    end

    // Receiver: checks each result item and stalls at random or for long holds.
    always @(posedge i_clk) begin
        t_verdict want;
        logic     stall;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                taken_results++;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with nothing expected, status",
                                    64'(res_ch.status), '0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch("status", 64'(res_ch.status), 64'(want.status));
                    if (res_ch.stored_mac !== want.stored_mac)
                        report_mismatch("stored_mac", 64'(res_ch.stored_mac),
                                        64'(want.stored_mac));
                    if (res_ch.entry_index !== want.entry_index)
                        report_mismatch("entry_index", 64'(res_ch.entry_index),
                                        64'(want.entry_index));
                end
            end
            // A long hold lets the block fill up and stall its input.
            if (hold_points.size() > 0 && taken_results >= hold_points[0]) begin
                hold_left = HOLD_CYCLES;
                void'(hold_points.pop_front());
            end
            if (hold_left > 0) begin
                stall = 1'b1;
                hold_left--;
            end else begin
                stall = !(taken_results >= QUIET_FIRST && taken_results < QUIET_LAST)
                        && ($urandom_range(99) < IDLE_PCT);
            end
            res_ch.ready <= !stall;
        end
    end

    // Watchdog: counts cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (arp_ch.valid && arp_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [abl_pkg::MAC_W-1:0] first_mac [bit [abl_pkg::IP_W-1:0]];
        logic [abl_pkg::IP_W-1:0]  pool_ip [POOL_SIZE];
        logic [abl_pkg::IP_W-1:0]  ip;
        logic [abl_pkg::MAC_W-1:0] mac;
        int               k;
        int               pick;

        arp_ch.valid      = 1'b0;
        arp_ch.arp_opcode = '0;
        arp_ch.sender_ip  = '0;
        arp_ch.sender_mac = '0;
        res_ch.ready      = 1'b0;

        // Non-reply opcodes are ignored, including near misses of the reply code.
        queue_msg(OP_REQUEST, 32'hC0A8_0001, 48'h0011_2233_4455);
        queue_msg('0, '1, '1);
        queue_msg('1, '0, '0);
        queue_msg(OP_REPLY_SWAPPED, 32'h0A00_0001, 48'hAAAA_5555_AAAA);
        queue_msg(OP_REPLY_HIGHBIT, 32'h0A00_0002, 48'h5555_AAAA_5555);
        queue_msg(OP_RARP_REQUEST, 32'h0A00_0003, 48'h0000_0000_0001);
        // Extreme IPs and MACs: learn, match, then spoof without overwriting.
        queue_msg(abl_pkg::REPLY_OPCODE, '0, '0);
        queue_msg(abl_pkg::REPLY_OPCODE, '1, '1);
        queue_msg(abl_pkg::REPLY_OPCODE, '0, '0);
        queue_msg(abl_pkg::REPLY_OPCODE, '1, '1);
        queue_msg(abl_pkg::REPLY_OPCODE, '0, '1);
        queue_msg(abl_pkg::REPLY_OPCODE, '1, '0);
        queue_msg(abl_pkg::REPLY_OPCODE, '0, '0);
        // An ignored request must not disturb a learned binding.
        queue_msg(abl_pkg::REPLY_OPCODE, 32'hC0A8_0001, 48'h0011_2233_4455);
        queue_msg(OP_REQUEST, 32'hC0A8_0001, 48'h0066_7788_99AA);
        queue_msg(abl_pkg::REPLY_OPCODE, 32'hC0A8_0001, 48'h0011_2233_4455);
        // IPs and MACs one bit apart from learned ones.
        queue_msg(abl_pkg::REPLY_OPCODE, 32'h0000_0001, '0);
        queue_msg(abl_pkg::REPLY_OPCODE, 32'h8000_0000, 48'h8000_0000_0000);
        queue_msg(abl_pkg::REPLY_OPCODE, 32'h8000_0000, 48'h8000_0000_0001);
        queue_msg(abl_pkg::REPLY_OPCODE, 32'h0000_0001, '0);

        // Random part: replies from a slowly growing pool of IPs, so that the
        // table fills during the run, plus noise and stray replies.
        for (k = 0; k < POOL_SIZE; k++)
            pool_ip[k] = $urandom;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                queue_msg(16'($urandom), $urandom, rand_mac());
            end else if (pick < 13) begin
                queue_msg(abl_pkg::REPLY_OPCODE, $urandom, rand_mac());
            end else begin
                ip = pool_ip[$urandom_range(6 + k * (POOL_SIZE - 7) / RANDOM_ITEMS)];
                if (!first_mac.exists(ip)) begin
                    mac           = rand_mac();
                    first_mac[ip] = mac;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 65)
                        mac = first_mac[ip];
                    else if (pick < 80)
                        mac = first_mac[ip]
                              ^ (48'd1 << $urandom_range(abl_pkg::MAC_W - 1));
                    else
                        mac = rand_mac();
                end
                queue_msg(abl_pkg::REPLY_OPCODE, ip, mac);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every message to be accepted and every result to arrive.
        while (!(arp_backlog.size() == 0 && !arp_ch.valid && expected_verdicts.size() == 0)
               && idle_run < STALL_LIMIT)
            @(negedge i_clk);

        if (idle_run >= STALL_LIMIT) begin
            $display("arp_binding_learn_check regression: fail");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (expected_verdicts.size() != 0)
                report_mismatch("results still missing",
                                64'(expected_verdicts.size()), '0);
            if (error_count == 0)
                $display("arp_binding_learn_check regression: pass");
            else
                $display("arp_binding_learn_check regression: fail");
            $finish;
        end
    end

endmodule

FILE: sim.f
rtl/core/abl_pkg.sv
rtl/core/abl_if.sv
rtl/core/abl_ram.sv
rtl/core/abl_dpath.sv
rtl/core/abl_ctrl.sv
rtl/core/arp_binding_learn_check.sv
tb/sv/testbench.sv
